// File: design/lwft_pkg.sv
// Package for the lowercase word frequency table.
// Beat structs, queue entry type and engine state enum; no dependencies.
package lwft_pkg;

  typedef struct packed {
    logic       kind;
    logic [7:0] text_byte;
    logic       end_of_text;
    logic [6:0] entry_index;
    logic [6:0] char_position;
  } in_item_t;

  typedef struct packed {
    logic [6:0]  slot;
    logic [15:0] occurrences;
    logic        is_new;
    logic        rejected;
    logic        table_full;
    logic [7:0]  stored_char;
    logic [7:0]  word_length;
    logic [7:0]  entries_used;
  } out_item_t;

  localparam logic KIND_TEXT = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam logic [7:0] CHAR_LO = 8'h61;  // 'a'
  localparam logic [7:0] CHAR_HI = 8'h7A;  // 'z'

  typedef enum logic [1:0] {
    OP_CHAR,
    OP_SPACE,
    OP_READ
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] ch;
    logic       eot;
    logic [6:0] idx;
    logic [6:0] pos;
  } q_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLOSE,
    S_LEN_RD,
    S_LEN_CHK,
    S_CMP_RD,
    S_CMP_CHK,
    S_CNT,
    S_COPY,
    S_COPY_WR,
    S_RDO,
    S_OUT
  } eng_state_t;

endpackage

// File: design/lwft_ram.sv
// Generic single write port RAM with registered read.
// No dependencies.
module lwft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/lwft_front.sv
// Front end: accepts input beats, classifies them, queues them (2 deep).
// Depends on lwft_pkg.
module lwft_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  lwft_pkg::in_item_t in_data,
  output logic              q_valid,
  output lwft_pkg::q_item_t q_item,
  input  logic              q_pop
);

  lwft_pkg::q_item_t slot_r [2];
  logic              wp_r, wp_nxt;
  logic              rp_r, rp_nxt;
  logic [1:0]        cnt_r, cnt_nxt;
  lwft_pkg::q_item_t cls;
  logic              push;
  logic              is_ws;

  always_comb begin
    is_ws = (in_data.text_byte == 8'h20) ||
            (in_data.text_byte >= 8'h09 && in_data.text_byte <= 8'h0D);
    cls.ch  = in_data.text_byte;
    cls.eot = in_data.end_of_text;
    cls.idx = in_data.entry_index;
    cls.pos = in_data.char_position;
    if (in_data.kind == lwft_pkg::KIND_READ) begin
      cls.op = lwft_pkg::OP_READ;
    end else if (is_ws) begin
      cls.op = lwft_pkg::OP_SPACE;
    end else begin
      cls.op = lwft_pkg::OP_CHAR;
    end
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = slot_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = q_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= cls;
    end
  end

endmodule

// File: design/lwft_back.sv
// Back end: pending word buffer, table walk, insert, entry read, result register.
// Depends on lwft_pkg and lwft_ram.
module lwft_back #(
  parameter int TABLE_ENTRIES = 128,
  parameter int WORD_CHARS    = 128,
  parameter int COUNT_BITS    = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  lwft_pkg::q_item_t  q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output lwft_pkg::out_item_t out_data
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int UC_W  = $clog2(TABLE_ENTRIES + 1);
  localparam int POS_W = $clog2(WORD_CHARS);
  localparam int LEN_W = $clog2(WORD_CHARS + 1);
  localparam int SD    = TABLE_ENTRIES * WORD_CHARS;
  localparam int SA_W  = $clog2(SD);
  localparam int BA_W  = $clog2(SD + 1);

  lwft_pkg::eng_state_t st_r, st_nxt;

  logic [LEN_W-1:0] plen_r, plen_nxt;
  logic             plong_r, plong_nxt;
  logic             plower_r, plower_nxt;
  logic [LEN_W-1:0] cur_len_r, cur_len_nxt;
  logic [UC_W-1:0]  used_r, used_nxt;
  logic [UC_W-1:0]  e_r, e_nxt;
  logic [BA_W-1:0]  base_r, base_nxt;
  logic [LEN_W-1:0] i_r, i_nxt;
  logic [6:0]       rd_idx_r, rd_idx_nxt;
  logic [6:0]       rd_pos_r, rd_pos_nxt;
  lwft_pkg::out_item_t res_r, res_nxt;
  lwft_pkg::out_item_t out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;

  // memory ports
  logic                  pw_we, sw_we, lw_we, cw_we;
  logic [POS_W-1:0]      pw_waddr, pw_raddr;
  logic [7:0]            pw_wdata, pw_rdata;
  logic [SA_W-1:0]       sw_waddr, sw_raddr;
  logic [7:0]            sw_rdata;
  logic [IDX_W-1:0]      lw_addr_w, lw_raddr;
  logic [LEN_W-1:0]      lw_rdata;
  logic [IDX_W-1:0]      cw_waddr, cw_raddr;
  logic [COUNT_BITS-1:0] cw_wdata, cw_rdata, cnt_inc;

  logic                  head_lower;
  logic                  out_free;
  logic                  rd_unused;
  logic                  rd_in_word;

  lwft_ram #(.WIDTH(8), .DEPTH(WORD_CHARS)) u_pend (
    .clk, .we(pw_we), .waddr(pw_waddr), .wdata(pw_wdata), .raddr(pw_raddr),
    .rdata(pw_rdata)
  );
  lwft_ram #(.WIDTH(8), .DEPTH(SD)) u_store (
    .clk, .we(sw_we), .waddr(sw_waddr), .wdata(pw_rdata), .raddr(sw_raddr),
    .rdata(sw_rdata)
  );
  lwft_ram #(.WIDTH(LEN_W), .DEPTH(TABLE_ENTRIES)) u_len (
    .clk, .we(lw_we), .waddr(lw_addr_w), .wdata(cur_len_r), .raddr(lw_raddr),
    .rdata(lw_rdata)
  );
  lwft_ram #(.WIDTH(COUNT_BITS), .DEPTH(TABLE_ENTRIES)) u_cnt (
    .clk, .we(cw_we), .waddr(cw_waddr), .wdata(cw_wdata), .raddr(cw_raddr),
    .rdata(cw_rdata)
  );

  assign head_lower = (q_item.ch >= lwft_pkg::CHAR_LO) && (q_item.ch <= lwft_pkg::CHAR_HI);
  assign out_free   = !out_valid_r || !out_stall;
  assign cnt_inc    = (cw_rdata == '1) ? cw_rdata : cw_rdata + COUNT_BITS'(1);
  assign rd_unused  = 32'(rd_idx_r) >= 32'(used_r);
  assign rd_in_word = (32'(rd_pos_r) < 32'(lw_rdata)) && (32'(rd_pos_r) < WORD_CHARS);

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      lwft_pkg::S_IDLE: begin
        if (q_valid) begin
          case (q_item.op)
            lwft_pkg::OP_CHAR:  st_nxt = q_item.eot ? lwft_pkg::S_CLOSE : lwft_pkg::S_IDLE;
            lwft_pkg::OP_SPACE: st_nxt = lwft_pkg::S_CLOSE;
            lwft_pkg::OP_READ:  st_nxt = lwft_pkg::S_RDO;
            default:            st_nxt = lwft_pkg::S_IDLE;
          endcase
        end
      end
      lwft_pkg::S_CLOSE: begin
        if (plen_r == '0) st_nxt = lwft_pkg::S_IDLE;
        else if (!plower_r || plong_r) st_nxt = lwft_pkg::S_OUT;
        else st_nxt = lwft_pkg::S_LEN_RD;
      end
      lwft_pkg::S_LEN_RD: begin
        if (e_r != used_r) st_nxt = lwft_pkg::S_LEN_CHK;
        else if (used_r >= UC_W'(TABLE_ENTRIES)) st_nxt = lwft_pkg::S_OUT;
        else st_nxt = lwft_pkg::S_COPY;
      end
      lwft_pkg::S_LEN_CHK:
        st_nxt = (lw_rdata == cur_len_r) ? lwft_pkg::S_CMP_RD : lwft_pkg::S_LEN_RD;
      lwft_pkg::S_CMP_RD:
        st_nxt = (i_r == cur_len_r) ? lwft_pkg::S_CNT : lwft_pkg::S_CMP_CHK;
      lwft_pkg::S_CMP_CHK:
        st_nxt = (pw_rdata == sw_rdata) ? lwft_pkg::S_CMP_RD : lwft_pkg::S_LEN_RD;
      lwft_pkg::S_CNT:     st_nxt = lwft_pkg::S_OUT;
      lwft_pkg::S_COPY:
        st_nxt = (i_r == cur_len_r) ? lwft_pkg::S_OUT : lwft_pkg::S_COPY_WR;
      lwft_pkg::S_COPY_WR: st_nxt = lwft_pkg::S_COPY;
      lwft_pkg::S_RDO:     st_nxt = lwft_pkg::S_OUT;
      lwft_pkg::S_OUT:     st_nxt = out_free ? lwft_pkg::S_IDLE : lwft_pkg::S_OUT;
      default:             st_nxt = lwft_pkg::S_IDLE;
    endcase
  end

  // memory controls and pop
  always_comb begin
    q_pop     = (st_r == lwft_pkg::S_IDLE) && q_valid;
    pw_we     = 1'b0;
    pw_waddr  = POS_W'(plen_r);
    pw_wdata  = q_item.ch;
    pw_raddr  = POS_W'(i_r);
    sw_we     = 1'b0;
    sw_waddr  = SA_W'(base_r + BA_W'(i_r));
    sw_raddr  = SA_W'(base_r + BA_W'(i_r));
    lw_we     = 1'b0;
    lw_addr_w = IDX_W'(used_r);
    lw_raddr  = IDX_W'(e_r);
    cw_we     = 1'b0;
    cw_waddr  = IDX_W'(e_r);
    cw_wdata  = cnt_inc;
    cw_raddr  = IDX_W'(e_r);
    case (st_r)
      lwft_pkg::S_IDLE: begin
        lw_raddr = IDX_W'(q_item.idx);
        cw_raddr = IDX_W'(q_item.idx);
        sw_raddr = SA_W'(32'(q_item.idx) * WORD_CHARS + 32'(q_item.pos));
        if (q_valid && q_item.op == lwft_pkg::OP_CHAR && !plong_r &&
            plen_r < LEN_W'(WORD_CHARS)) begin
          pw_we = 1'b1;
        end
      end
      lwft_pkg::S_CNT:     cw_we = 1'b1;
      lwft_pkg::S_COPY: begin
        if (i_r == cur_len_r) begin
          lw_we    = 1'b1;
          cw_we    = 1'b1;
          cw_waddr = IDX_W'(used_r);
          cw_wdata = COUNT_BITS'(1);
        end
      end
      lwft_pkg::S_COPY_WR: sw_we = 1'b1;
      default: ;
    endcase
  end

  // datapath registers
  always_comb begin
    plen_nxt      = plen_r;
    plong_nxt     = plong_r;
    plower_nxt    = plower_r;
    cur_len_nxt   = cur_len_r;
    used_nxt      = used_r;
    e_nxt         = e_r;
    base_nxt      = base_r;
    i_nxt         = i_r;
    rd_idx_nxt    = rd_idx_r;
    rd_pos_nxt    = rd_pos_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (st_r)
      lwft_pkg::S_IDLE: begin
        rd_idx_nxt = q_item.idx;
        rd_pos_nxt = q_item.pos;
        if (q_valid && q_item.op == lwft_pkg::OP_CHAR) begin
          if (!head_lower) plower_nxt = 1'b0;
          if (!plong_r && plen_r < LEN_W'(WORD_CHARS)) plen_nxt = plen_r + LEN_W'(1);
          else plong_nxt = 1'b1;
        end
      end
      lwft_pkg::S_CLOSE: begin
        cur_len_nxt = plen_r;
        plen_nxt    = '0;
        plong_nxt   = 1'b0;
        plower_nxt  = 1'b1;
        e_nxt       = '0;
        base_nxt    = '0;
        res_nxt              = '0;
        res_nxt.rejected     = 1'b1;
        res_nxt.word_length  = 8'(plen_r);
        res_nxt.entries_used = 8'(used_r);
      end
      lwft_pkg::S_LEN_RD: begin
        i_nxt                = '0;
        res_nxt              = '0;
        res_nxt.table_full   = 1'b1;
        res_nxt.word_length  = 8'(cur_len_r);
        res_nxt.entries_used = 8'(used_r);
      end
      lwft_pkg::S_LEN_CHK: begin
        i_nxt = '0;
        if (lw_rdata != cur_len_r) begin
          e_nxt    = e_r + UC_W'(1);
          base_nxt = base_r + BA_W'(WORD_CHARS);
        end
      end
      lwft_pkg::S_CMP_CHK: begin
        if (pw_rdata == sw_rdata) begin
          i_nxt = i_r + LEN_W'(1);
        end else begin
          e_nxt    = e_r + UC_W'(1);
          base_nxt = base_r + BA_W'(WORD_CHARS);
        end
      end
      lwft_pkg::S_CNT: begin
        res_nxt              = '0;
        res_nxt.slot         = 7'(e_r);
        res_nxt.occurrences  = 16'(cnt_inc);
        res_nxt.word_length  = 8'(cur_len_r);
        res_nxt.entries_used = 8'(used_r);
      end
      lwft_pkg::S_COPY: begin
        if (i_r == cur_len_r) begin
          used_nxt             = used_r + UC_W'(1);
          res_nxt              = '0;
          res_nxt.slot         = 7'(used_r);
          res_nxt.occurrences  = 16'd1;
          res_nxt.is_new       = 1'b1;
          res_nxt.word_length  = 8'(cur_len_r);
          res_nxt.entries_used = 8'(used_r + UC_W'(1));
        end
      end
      lwft_pkg::S_COPY_WR: i_nxt = i_r + LEN_W'(1);
      lwft_pkg::S_RDO: begin
        res_nxt              = '0;
        res_nxt.slot         = rd_idx_r;
        res_nxt.entries_used = 8'(used_r);
        if (!rd_unused) begin
          res_nxt.occurrences = 16'(cw_rdata);
          res_nxt.word_length = 8'(lw_rdata);
          res_nxt.stored_char = rd_in_word ? sw_rdata : 8'h00;
        end
      end
      lwft_pkg::S_OUT: begin
        if (out_free) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= lwft_pkg::S_IDLE;
      plen_r      <= '0;
      plong_r     <= 1'b0;
      plower_r    <= 1'b1;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      plen_r      <= plen_nxt;
      plong_r     <= plong_nxt;
      plower_r    <= plower_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_len_r <= cur_len_nxt;
    e_r       <= e_nxt;
    base_r    <= base_nxt;
    i_r       <= i_nxt;
    rd_idx_r  <= rd_idx_nxt;
    rd_pos_r  <= rd_pos_nxt;
    res_r     <= res_nxt;
    out_r     <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: design/lowercase_word_frequency_table.sv
// Word frequency table: counts distinct lowercase words in a byte stream.
// The engine handles one queue item at a time: a text byte that does not close a word, an entry
// read, or a word close, which walks the stored entries (length, then chars compared), rejects
// bad words and on insert copies the word in. Throughput bounded by this table walk on the single engine.
// Reset (synchronous, rst_n low) clears the queue, pending word state and used count;
// stored words need no clearing pass since only slots below the used count are read.
module lowercase_word_frequency_table #(
  parameter int TABLE_ENTRIES = 128,
  parameter int WORD_CHARS    = 128,
  parameter int COUNT_BITS    = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lwft_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output lwft_pkg::out_item_t out_data
);

  // two-deep queue between classifier and engine
  logic              q_valid;
  logic              q_pop;
  lwft_pkg::q_item_t q_item;

  // front: accepts beats and tags them as char, whitespace or read
  lwft_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .q_valid, .q_item, .q_pop
  );

  // back: pending word, linear table walk, insert copy, result register
  lwft_back #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .WORD_CHARS(WORD_CHARS),
    .COUNT_BITS(COUNT_BITS)
  ) u_back (
    .clk, .rst_n, .q_valid, .q_item, .q_pop,
    .out_valid, .out_stall, .out_data
  );

endmodule

// File: design/lwft_checker.sv
// Port-level checks for the word frequency table, bound to the top level.
// Depends on lwft_pkg.
module lwft_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input lwft_pkg::out_item_t out_data
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  a_new: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_new |->
      out_data.occurrences == 16'd1 && !out_data.rejected && !out_data.table_full &&
      out_data.word_length != 8'd0 && out_data.entries_used != 8'd0)
    else $error("bad new-word beat");

  a_rej: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.rejected || out_data.table_full) |->
      out_data.slot == 7'd0 && out_data.occurrences == 16'd0 && !out_data.is_new)
    else $error("bad rejected or full beat");

endmodule

bind lowercase_word_frequency_table lwft_checker u_chk (
  .clk, .rst_n, .out_valid, .out_stall, .out_data
);

// File: tb/sv/lowercase_word_frequency_table_test.sv
// Self-checking testbench for lowercase_word_frequency_table.
// Depends on lwft_pkg and the block; an internal word table model predicts each result beat.
module lowercase_word_frequency_table_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = 128;
  localparam int NCHR  = 128;
  localparam int CMAX  = 65535;

  // Word table model plus the queue of expected result beats.
  class word_table_board;
    byte unsigned store_q[NSLOT][$];
    int unsigned  counts[NSLOT];
    int unsigned  used;
    byte unsigned pend[$];
    int unsigned  pend_len;
    bit           pend_lower;
    lwft_pkg::out_item_t due_q[$];
    int           errors;

    function new();
      used = 0;
      pend_len = 0;
      pend_lower = 1;
      errors = 0;
    endfunction

    function void push_res(logic [6:0] s, int unsigned occ, bit nw, bit rej, bit full,
                           byte unsigned ch, int unsigned len);
      lwft_pkg::out_item_t r;
      r.slot = s;
      r.occurrences = occ[15:0];
      r.is_new = nw;
      r.rejected = rej;
      r.table_full = full;
      r.stored_char = ch;
      r.word_length = len[7:0];
      r.entries_used = used[7:0];
      due_q.push_back(r);
    endfunction

    function void close_word();
      int unsigned len;
      bit lower;
      bit hit;
      len = pend_len;
      lower = pend_lower;
      pend_len = 0;
      pend_lower = 1;
      if (len == 0) return;
      if (!lower || len > NCHR) begin
        push_res(0, 0, 0, 1, 0, 0, (len > NCHR) ? NCHR : len);
        pend.delete();
        return;
      end
      for (int e = 0; e < used; e++) begin
        hit = (store_q[e].size() == len);
        for (int i = 0; hit && i < len; i++)
          if (store_q[e][i] != pend[i]) hit = 0;
        if (hit) begin
          if (counts[e] < CMAX) counts[e]++;
          push_res(7'(e), counts[e], 0, 0, 0, 0, len);
          pend.delete();
          return;
        end
      end
      if (used >= NSLOT) begin
        push_res(0, 0, 0, 0, 1, 0, len);
      end else begin
        store_q[used] = pend;
        counts[used] = 1;
        used++;
        push_res(7'(used - 1), 1, 1, 0, 0, 0, len);
      end
      pend.delete();
    endfunction

    // Note an accepted input beat.
    function void note_input(lwft_pkg::in_item_t it);
      byte unsigned ch;
      if (it.kind == lwft_pkg::KIND_READ) begin
        if (it.entry_index >= used) begin
          push_res(it.entry_index, 0, 0, 0, 0, 0, 0);
        end else begin
          ch = (it.char_position < store_q[it.entry_index].size()) ?
               store_q[it.entry_index][it.char_position] : 0;
          push_res(it.entry_index, counts[it.entry_index], 0, 0, 0, ch,
                   store_q[it.entry_index].size());
        end
        return;
      end
      if (it.text_byte == 8'h20 || (it.text_byte >= 8'h09 && it.text_byte <= 8'h0D)) begin
        close_word();
        return;
      end
      if (it.text_byte < lwft_pkg::CHAR_LO || it.text_byte > lwft_pkg::CHAR_HI) pend_lower = 0;
      if (pend_len < NCHR) begin
        pend.push_back(it.text_byte);
        pend_len++;
      end else begin
        pend_len = NCHR + 1;
      end
      if (it.end_of_text) close_word();
    endfunction

    // Check an accepted result beat against the oldest expectation.
    function void check_result(lwft_pkg::out_item_t got);
      lwft_pkg::out_item_t exp_r;
      if (due_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %p", got);
        return;
      end
      exp_r = due_q.pop_front();
      if (got !== exp_r) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p actual %p", exp_r, got);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  lwft_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 0;
  lwft_pkg::out_item_t out_data;

  word_table_board board = new();
  longint cycles = 0;
  bit quiet = 0;          // no idling in the final part of the run
  bit hold_rx = 0;        // receiver long hold-off request
  int sent = 0;

  lowercase_word_frequency_table DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #5 clk = ~clk;

  // Sample both channels at the rising edge.
  always @(posedge clk) begin
    cycles++;
    if (rst_n && in_valid && !in_stall) board.note_input(in_data);
    if (rst_n && out_valid && !out_stall) board.check_result(out_data);
    if (cycles > 20000000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_rx) begin
        out_stall <= 1;
        for (int i = 0; i < 400; i++) @(negedge clk);
        hold_rx = 0;
        out_stall <= 0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 10);
        out_stall <= 1;
        repeat (n) @(negedge clk);
        out_stall <= 0;
      end
    end
  end

  // Offer one beat and hold it until accepted; random gaps in front.
  task automatic send_beat(lwft_pkg::in_item_t it);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_valid <= 1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    sent++;
  endtask

  task automatic send_text(byte unsigned b, bit eot);
    lwft_pkg::in_item_t it;
    it = '0;
    it.kind = lwft_pkg::KIND_TEXT;
    it.text_byte = b;
    it.end_of_text = eot;
    it.entry_index = 7'($urandom);
    it.char_position = 7'($urandom);
    send_beat(it);
  endtask

  task automatic send_read(logic [6:0] idx, logic [6:0] pos);
    lwft_pkg::in_item_t it;
    it.kind = lwft_pkg::KIND_READ;
    it.text_byte = 8'($urandom);
    it.end_of_text = 1'($urandom);
    it.entry_index = idx;
    it.char_position = pos;
    send_beat(it);
  endtask

  // A short lowercase word from a small alphabet so repeats are common;
  // closed by a whitespace byte or by end_of_text on its last letter.
  task automatic send_word();
    int len;
    bit by_eot;
    byte unsigned ws[6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
    len = $urandom_range(1, 4);
    by_eot = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < len; i++)
      send_text(8'(lwft_pkg::CHAR_LO + $urandom_range(0, (i == 0) ? 25 : 3)),
                by_eot && i == len - 1);
    if (!by_eot) send_text(ws[$urandom_range(0, 5)], 0);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.due_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  initial begin
    rst_n = 0;
    repeat (4) @(negedge clk);
    rst_n = 1;

    // Directed: empty closes, reads of unused slots, insert, match, reads.
    send_text(8'h20, 0);
    send_text(8'h0D, 1);
    send_read(0, 0);
    send_read(7'h7F, 7'h7F);
    send_text("a", 0); send_text("b", 0); send_text(8'h20, 0);  // new word
    send_text("a", 0); send_text("b", 1);                       // match via eot
    send_text("z", 0); send_text(8'h09, 1);                     // whitespace with eot
    send_text(8'h00, 0); send_text(8'h0A, 0);                   // rejected (0x00)
    send_text(8'hFF, 0); send_text("A", 1);                     // rejected
    send_read(0, 0); send_read(0, 1); send_read(0, 2);          // read past end
    send_read(1, 0);
    // Too long word: 130 letters then close.
    for (int i = 0; i < 130; i++) send_text("q", 0);
    send_text(8'h20, 0);
    // Exactly word limit length, inserted.
    for (int i = 0; i < 128; i++) send_text("k", i == 127);
    send_read(2, 127);
    drain();  // sender pause until every result has come

    // Long receiver hold-off while the sender keeps going.
    hold_rx = 1;
    for (int i = 0; i < 60; i++) send_word();

    // Random part: mostly words, some reads and noise bytes.
    while (sent < 800) begin
      case ($urandom_range(0, 9))
        0: send_read(7'($urandom_range(0, board.used + 2)), 7'($urandom_range(0, 5)));
        1: send_read(7'($urandom), 7'($urandom));
        2: send_text(8'($urandom), 1'($urandom));
        default: send_word();
      endcase
    end
    // Fill the table with distinct words to reach the full case.
    for (int i = 0; i < 140; i++) begin
      send_text(8'(lwft_pkg::CHAR_LO + i % 26), 0);
      send_text(8'(lwft_pkg::CHAR_LO + i / 26), 0);
      send_text("x", 0);
      send_text(8'h20, 0);
    end
    quiet = 1;
    for (int i = 0; i < 40; i++) begin
      send_word();
      send_read(7'($urandom), 7'($urandom_range(0, 3)));
    end
    drain();
    if (board.errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
